// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the Adam update block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error("assertion failed: invariant violated");

// Checks that a condition in one cycle is followed by another in the next.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check violated");

`else

`define ASSERT_ALWAYS(name, clk, rst_n, expr)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/adam_pkg.sv -----
// Shared widths, constants and types of the Adam parameter update block.
`timescale 1ns / 1ps

package adam_pkg;

  localparam int PARAM_COUNT = 1024;
  localparam int IDX_W       = $clog2(PARAM_COUNT);

  localparam int GRAD_W  = 32;
  localparam int THETA_W = 32;
  localparam int M_W     = 32;
  localparam int V_W     = 64;
  localparam int POW_W   = 32;
  localparam int LR_W    = 24;
  localparam int BETA_W  = 16;
  localparam int EPS_W   = 16;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_ONE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_TWO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 2'd3;

  localparam logic [LR_W-1:0]   LEARN_RATE_RST = 24'd65536;
  localparam logic [BETA_W-1:0] BETA_ONE_RST   = 16'd58982;
  localparam logic [BETA_W-1:0] BETA_TWO_RST   = 16'd65470;
  localparam logic [EPS_W-1:0]  EPSILON_RST    = 16'd3;

  // Bit steps of the pipelined dividers and of the square root.
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int FDIV_STEPS = 41;

  // Item identity that travels alongside the arithmetic.
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [THETA_W-1:0] theta;
    logic               neg;
  } tag_t;

endpackage

// ----- rtl/adam_parameter_update.sv -----
// Adam parameter update: moment stores, bias correction, root and division pipeline.
// Stages P, Q and L, 64-step dividers, a 32-step root, product registers, a 41-step divider.
// Throughput: one beat per cycle while the output is not stalled and clearing is done.
// The whole pipeline holds while a finished result waits and the output is stalled.
// After reset the moment stores are cleared, all 1024 entries; no input beat is taken meanwhile.
// Reset restores the configuration defaults and sets both beta powers to all ones.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adam_parameter_update
  import adam_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // Input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [IDX_W-1:0]     param_index_i,
  input  logic [GRAD_W-1:0]    gradient_i,
  input  logic [THETA_W-1:0]   theta_in_i,
  input  logic                 new_step_i,
  // Output channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IDX_W-1:0]     index_out_o,
  output logic [THETA_W-1:0]   theta_out_o
);

  // ---------------------------------------------------------------------------
  // Pipeline control. Every stage moves together; the only holding point is the
  // output register, so the pipeline advances unless that register is full and
  // the consumer stalls it.
  // ---------------------------------------------------------------------------
  logic adv;
  logic in_acc;
  logic out_vld_q;
  logic clr_busy_q;
  logic [IDX_W-1:0] clr_addr_q;

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = clr_busy_q || !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [LR_W-1:0]   learn_rate_q;
  logic [BETA_W-1:0] beta_one_q;
  logic [BETA_W-1:0] beta_two_q;
  logic [EPS_W-1:0]  epsilon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_rate_q <= LEARN_RATE_RST;
      beta_one_q   <= BETA_ONE_RST;
      beta_two_q   <= BETA_TWO_RST;
      epsilon_q    <= EPSILON_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEARN_RATE: learn_rate_q <= cfg_wdata_i;
        REG_BETA_ONE:   beta_one_q   <= cfg_wdata_i[BETA_W-1:0];
        REG_BETA_TWO:   beta_two_q   <= cfg_wdata_i[BETA_W-1:0];
        REG_EPSILON:    epsilon_q    <= cfg_wdata_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass. The moment stores are written with zero, one entry per
  // cycle, before the first beat is taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == IDX_W'(PARAM_COUNT - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Running beta powers, advanced when a beat opens a new step. The beat itself
  // already sees the advanced powers, and carries the bias terms 2^32 - power.
  // ---------------------------------------------------------------------------
  logic [POW_W-1:0]  pow1_q, pow2_q;
  logic [47:0]       pow1_prod, pow2_prod;
  logic [POW_W-1:0]  pow1_use, pow2_use;
  logic [POW_W:0]    bias1, bias2;

  assign pow1_prod = 48'(pow1_q) * 48'(beta_one_q);
  assign pow2_prod = 48'(pow2_q) * 48'(beta_two_q);
  assign pow1_use  = new_step_i ? pow1_prod[47:16] : pow1_q;
  assign pow2_use  = new_step_i ? pow2_prod[47:16] : pow2_q;
  assign bias1     = {1'b1, {POW_W{1'b0}}} - {1'b0, pow1_use};
  assign bias2     = {1'b1, {POW_W{1'b0}}} - {1'b0, pow2_use};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow1_q <= '1;
      pow2_q <= '1;
    end else if (in_acc && new_step_i) begin
      pow1_q <= pow1_use;
      pow2_q <= pow2_use;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage P: input beat registered.
  // ---------------------------------------------------------------------------
  logic               p_vld_q;
  logic [IDX_W-1:0]   p_idx_q;
  logic [GRAD_W-1:0]  p_g_q;
  logic [THETA_W-1:0] p_theta_q;
  logic [POW_W:0]     p_b1_q, p_b2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (adv) begin
      p_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_idx_q   <= param_index_i;
      p_g_q     <= gradient_i;
      p_theta_q <= theta_in_i;
      p_b1_q    <= bias1;
      p_b2_q    <= bias2;
    end
  end

  // Gradient weighted by (1 - beta1) and the gradient squared.
  logic [16:0]        kc1, kc2;
  logic signed [48:0] kc1_s, g_s, p_c1;
  logic [GRAD_W-1:0]  p_gabs;
  logic [63:0]        p_gg;

  assign kc1    = 17'd65536 - 17'(beta_one_q);
  assign kc2    = 17'd65536 - 17'(beta_two_q);
  assign kc1_s  = {32'b0, kc1};
  assign g_s    = {{17{p_g_q[GRAD_W-1]}}, p_g_q};
  assign p_c1   = kc1_s * g_s;
  assign p_gabs = p_g_q[GRAD_W-1] ? (~p_g_q + 1'b1) : p_g_q;
  assign p_gg   = 64'(p_gabs) * 64'(p_gabs);

  // ---------------------------------------------------------------------------
  // Stage Q: weight the squared gradient by (1 - beta2), split in halves.
  // ---------------------------------------------------------------------------
  logic               q_vld_q;
  logic [IDX_W-1:0]   q_idx_q;
  logic [THETA_W-1:0] q_theta_q;
  logic [POW_W:0]     q_b1_q, q_b2_q;
  logic signed [48:0] q_c1_q;
  logic [63:0]        q_gg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q <= 1'b0;
    end else if (adv) begin
      q_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q_idx_q   <= p_idx_q;
      q_theta_q <= p_theta_q;
      q_b1_q    <= p_b1_q;
      q_b2_q    <= p_b2_q;
      q_c1_q    <= p_c1;
      q_gg_q    <= p_gg;
    end
  end

  logic [49:0] q_gk_hi, q_gk_lo;

  assign q_gk_hi = 50'(q_gg_q[63:32]) * 50'(kc2);
  assign q_gk_lo = 50'(q_gg_q[31:0]) * 50'(kc2) + 50'd32768;

  // ---------------------------------------------------------------------------
  // Stage L: moment read-modify-write. The store is read as a beat enters this
  // stage; the beat just ahead writes at that same edge, so its result is
  // forwarded from the first divider stage.
  // ---------------------------------------------------------------------------
  logic               l_vld_q;
  logic [IDX_W-1:0]   l_idx_q;
  logic [THETA_W-1:0] l_theta_q;
  logic [POW_W:0]     l_b1_q, l_b2_q;
  logic signed [48:0] l_c1_q;
  logic [49:0]        l_gk_hi_q, l_gk_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_vld_q <= 1'b0;
    end else if (adv) begin
      l_vld_q <= q_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_idx_q   <= q_idx_q;
      l_theta_q <= q_theta_q;
      l_b1_q    <= q_b1_q;
      l_b2_q    <= q_b2_q;
      l_c1_q    <= q_c1_q;
      l_gk_hi_q <= q_gk_hi;
      l_gk_lo_q <= q_gk_lo;
    end
  end

  logic [M_W-1:0]   m_rdata, m_wdata, m_src, l_mnew;
  logic [V_W-1:0]   v_rdata, v_wdata, v_src, l_vnew;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;

  // First divider stage doubles as the forwarding register of the moments.
  logic             dv_vld_q [DIV_STEPS+1];
  tag_t             dv_tag_q [DIV_STEPS+1];
  logic [M_W-1:0]   w_m_q;
  logic [V_W-1:0]   w_v_q;
  logic             fwd_hit;

  assign fwd_hit = dv_vld_q[0] && (dv_tag_q[0].idx == l_idx_q);
  assign m_src   = fwd_hit ? w_m_q : m_rdata;
  assign v_src   = fwd_hit ? w_v_q : v_rdata;

  logic signed [48:0] b1w_s, m_s, l_msum;
  logic [49:0]        l_vhi;
  logic [50:0]        l_vlo;
  logic [64:0]        l_vsum;

  assign b1w_s  = {33'b0, beta_one_q};
  assign m_s    = {{17{m_src[M_W-1]}}, m_src};
  assign l_msum = b1w_s * m_s + l_c1_q + 49'sd32768;
  assign l_mnew = l_msum[47:16];

  // Second moment in two 32-bit halves, then saturated to 64 bits.
  assign l_vhi  = 50'(v_src[63:32]) * 50'(beta_two_q) + l_gk_hi_q;
  assign l_vlo  = 51'(v_src[31:0]) * 51'(beta_two_q) + 51'(l_gk_lo_q);
  assign l_vsum = 65'({l_vhi[47:0], 16'b0}) + 65'(l_vlo[50:16]);
  assign l_vnew = (|l_vhi[49:48] || l_vsum[64]) ? '1 : l_vsum[63:0];

  logic [M_W-1:0] l_mmag;
  assign l_mmag = l_mnew[M_W-1] ? (~l_mnew + 1'b1) : l_mnew;

  assign ram_we    = clr_busy_q || (adv && l_vld_q);
  assign ram_waddr = clr_busy_q ? clr_addr_q : l_idx_q;
  assign m_wdata   = clr_busy_q ? '0 : l_mnew;
  assign v_wdata   = clr_busy_q ? '0 : l_vnew;

  adam_ram #(
    .WIDTH (M_W),
    .DEPTH (PARAM_COUNT)
  ) u_first_moment (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (m_wdata),
    .re_i    (adv),
    .raddr_i (q_idx_q),
    .rdata_o (m_rdata)
  );

  adam_ram #(
    .WIDTH (V_W),
    .DEPTH (PARAM_COUNT)
  ) u_second_moment (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (v_wdata),
    .re_i    (adv),
    .raddr_i (q_idx_q),
    .rdata_o (v_rdata)
  );

  // ---------------------------------------------------------------------------
  // Bias correction: two restoring dividers side by side, one quotient bit per
  // stage. Lane one gives |m| * 2^32 / b1, lane two v * 2^32 / b2. Each lane
  // keeps a remainder and a word that shifts the dividend out at the top while
  // the quotient fills in at the bottom.
  // ---------------------------------------------------------------------------
  logic [POW_W:0]   dv_d1_q  [DIV_STEPS+1];
  logic [POW_W:0]   dv_d2_q  [DIV_STEPS+1];
  logic [POW_W:0]   dv_r1_q  [DIV_STEPS+1];
  logic [POW_W:0]   dv_r2_q  [DIV_STEPS+1];
  logic [63:0]      dv_qd1_q [DIV_STEPS+1];
  logic [63:0]      dv_qd2_q [DIV_STEPS+1];
  logic             dv_sat_q [1:DIV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_q[0] <= l_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_tag_q[0] <= '{idx: l_idx_q, theta: l_theta_q, neg: l_mnew[M_W-1]};
      w_m_q       <= l_mnew;
      w_v_q       <= l_vnew;
      dv_d1_q[0]  <= l_b1_q;
      dv_d2_q[0]  <= l_b2_q;
      dv_r1_q[0]  <= '0;
      dv_qd1_q[0] <= {l_mmag, 32'b0};
      dv_r2_q[0]  <= {1'b0, l_vnew[63:32]};
      dv_qd2_q[0] <= {l_vnew[31:0], 32'b0};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [POW_W+1:0] t1, t2;
    logic             ge1, ge2;
    logic             sat_n;

    assign t1  = {dv_r1_q[k], dv_qd1_q[k][63]};
    assign t2  = {dv_r2_q[k], dv_qd2_q[k][63]};
    assign ge1 = t1 >= {1'b0, dv_d1_q[k]};
    assign ge2 = t2 >= {1'b0, dv_d2_q[k]};

    // The high half of v at or above b2 means the quotient overflows 64 bits.
    if (k == 0) begin : g_first
      assign sat_n = dv_r2_q[0] >= dv_d2_q[0];
    end else begin : g_rest
      assign sat_n = dv_sat_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_tag_q[k+1] <= dv_tag_q[k];
        dv_d1_q[k+1]  <= dv_d1_q[k];
        dv_d2_q[k+1]  <= dv_d2_q[k];
        dv_r1_q[k+1]  <= ge1 ? POW_W'(t1 - {1'b0, dv_d1_q[k]}) + 33'd0 : t1[POW_W:0];
        dv_r2_q[k+1]  <= ge2 ? POW_W'(t2 - {1'b0, dv_d2_q[k]}) + 33'd0 : t2[POW_W:0];
        dv_qd1_q[k+1] <= {dv_qd1_q[k][62:0], ge1};
        dv_qd2_q[k+1] <= {dv_qd2_q[k][62:0], ge2};
        dv_sat_q[k+1] <= sat_n;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Integer square root of the corrected second moment, one root bit per stage.
  // ---------------------------------------------------------------------------
  logic        sq_vld_q  [SQRT_STEPS+1];
  tag_t        sq_tag_q  [SQRT_STEPS+1];
  logic [63:0] sq_mhat_q [SQRT_STEPS+1];
  logic [63:0] sq_x_q    [SQRT_STEPS+1];
  logic [33:0] sq_rem_q  [SQRT_STEPS+1];
  logic [31:0] sq_root_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_q[0] <= dv_vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_tag_q[0]  <= dv_tag_q[DIV_STEPS];
      sq_mhat_q[0] <= dv_qd1_q[DIV_STEPS];
      sq_x_q[0]    <= dv_sat_q[DIV_STEPS] ? '1 : dv_qd2_q[DIV_STEPS];
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    assign rem_sh = {sq_rem_q[k], sq_x_q[k][63:62]};
    assign trial  = {2'b0, sq_root_q[k], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_tag_q[k+1]  <= sq_tag_q[k];
        sq_mhat_q[k+1] <= sq_mhat_q[k];
        sq_x_q[k+1]    <= {sq_x_q[k][61:0], 2'b00};
        sq_rem_q[k+1]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        sq_root_q[k+1] <= {sq_root_q[k][30:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Denominator and the numerator learn_rate * mhat as two partial products.
  // ---------------------------------------------------------------------------
  logic        mu_vld_q;
  tag_t        mu_tag_q;
  logic [32:0] mu_den_q;
  logic [55:0] mu_pp_lo_q, mu_pp_hi_q;
  logic [32:0] den_raw;

  assign den_raw = 33'(sq_root_q[SQRT_STEPS]) + 33'(epsilon_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_vld_q <= 1'b0;
    end else if (adv) begin
      mu_vld_q <= sq_vld_q[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mu_tag_q   <= sq_tag_q[SQRT_STEPS];
      // A zero denominator only occurs with zero v and zero epsilon; use one.
      mu_den_q   <= (den_raw == '0) ? 33'd1 : den_raw;
      mu_pp_lo_q <= 56'(learn_rate_q) * 56'(sq_mhat_q[SQRT_STEPS][31:0]);
      mu_pp_hi_q <= 56'(learn_rate_q) * 56'(sq_mhat_q[SQRT_STEPS][63:32]);
    end
  end

  logic        sm_vld_q;
  tag_t        sm_tag_q;
  logic [32:0] sm_den_q;
  logic [87:0] sm_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_vld_q <= 1'b0;
    end else if (adv) begin
      sm_vld_q <= mu_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sm_tag_q <= mu_tag_q;
      sm_den_q <= mu_den_q;
      sm_num_q <= {mu_pp_hi_q, 32'b0} + 88'(mu_pp_lo_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Final division. Only quotients up to the 2^40 cap matter, so 41 quotient
  // bits are formed; a high part at or above the denominator saturates.
  // ---------------------------------------------------------------------------
  logic        fd_vld_q [FDIV_STEPS+1];
  tag_t        fd_tag_q [FDIV_STEPS+1];
  logic [32:0] fd_den_q [FDIV_STEPS+1];
  logic [32:0] fd_r_q   [FDIV_STEPS+1];
  logic [40:0] fd_qd_q  [FDIV_STEPS+1];
  logic        fd_sat_q [FDIV_STEPS+1];
  logic        fd_over;

  assign fd_over = sm_num_q[87:41] >= 47'(sm_den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_vld_q[0] <= 1'b0;
    end else if (adv) begin
      fd_vld_q[0] <= sm_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fd_tag_q[0] <= sm_tag_q;
      fd_den_q[0] <= sm_den_q;
      fd_r_q[0]   <= fd_over ? '0 : sm_num_q[73:41];
      fd_qd_q[0]  <= sm_num_q[40:0];
      fd_sat_q[0] <= fd_over;
    end
  end

  for (genvar k = 0; k < FDIV_STEPS; k++) begin : g_fdiv
    logic [33:0] t;
    logic        ge;

    assign t  = {fd_r_q[k], fd_qd_q[k][40]};
    assign ge = t >= {1'b0, fd_den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fd_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        fd_vld_q[k+1] <= fd_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        fd_tag_q[k+1] <= fd_tag_q[k];
        fd_den_q[k+1] <= fd_den_q[k];
        fd_r_q[k+1]   <= ge ? 33'(t - {1'b0, fd_den_q[k]}) : t[32:0];
        fd_qd_q[k+1]  <= {fd_qd_q[k][39:0], ge};
        fd_sat_q[k+1] <= fd_sat_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output: apply the capped step against the sign of m and saturate.
  // ---------------------------------------------------------------------------
  localparam logic [40:0] DeltaCap = 41'(1) << 40;

  logic [40:0]        delta;
  logic signed [41:0] theta_s, res_s;
  logic [THETA_W-1:0] res_sat;
  logic [IDX_W-1:0]   out_idx_q;
  logic [THETA_W-1:0] out_theta_q;
  tag_t               fin_tag;

  assign fin_tag = fd_tag_q[FDIV_STEPS];
  assign delta   = (fd_sat_q[FDIV_STEPS] || fd_qd_q[FDIV_STEPS] > DeltaCap) ?
                   DeltaCap : fd_qd_q[FDIV_STEPS];
  assign theta_s = {{10{fin_tag.theta[THETA_W-1]}}, fin_tag.theta};
  assign res_s   = fin_tag.neg ? theta_s + $signed({1'b0, delta})
                               : theta_s - $signed({1'b0, delta});

  always_comb begin
    if (!res_s[41] && |res_s[40:31]) begin
      res_sat = {1'b0, {(THETA_W-1){1'b1}}};
    end else if (res_s[41] && !(&res_s[40:31])) begin
      res_sat = {1'b1, {(THETA_W-1){1'b0}}};
    end else begin
      res_sat = res_s[THETA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= fd_vld_q[FDIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_idx_q   <= fin_tag.idx;
      out_theta_q <= res_sat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign index_out_o = out_idx_q;
  assign theta_out_o = out_theta_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_no_beat_while_clearing, clk_i, rst_ni, !(clr_busy_q && in_acc))
  `ASSERT_ALWAYS(a_store_write_source, clk_i, rst_ni, !ram_we || clr_busy_q || l_vld_q)
  `ASSERT_NEXT(a_pow1_holds, clk_i, rst_ni, !(in_acc && new_step_i), $stable(pow1_q))
  `ASSERT_NEXT(a_pow2_holds, clk_i, rst_ni, !(in_acc && new_step_i), $stable(pow2_q))

endmodule

// ----- rtl/adam_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module adam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
